// ===== rtl/fea_pkg.sv =====
// fea_pkg: shared types and codes for the free extent allocator
// depends on nothing
package fea_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_LEN  = 3'd1,
        ST_BAD_ALIGN = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_SCAN_WAIT,
        S_REM,
        S_APPLY,
        S_SHIFT_UP,
        S_SHIFT_UP_WR,
        S_SHIFT_DN,
        S_SHIFT_DN_WR,
        S_FINAL,
        S_DONE
    } state_t;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // page size in bytes, a power of two
    localparam int PAGE_BYTES = 4096;

endpackage

// ===== rtl/fea_divider.sv =====
// fea_divider: bit-serial remainder unit, one quotient bit per cycle
// depends on nothing
module fea_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] remainder
);

    logic [64:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg[63:0], num_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (go)
        begin
            rem_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[64] ? shifted : diff;
            num_next = {num_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done      = busy_reg && (cnt_reg == 7'd1);
    assign remainder = rem_next[63:0];

endmodule

// ===== rtl/free_extent_allocator.sv =====
// free_extent_allocator: top level with sequencer and the extent table memory
// depends on fea_pkg and fea_divider
//
// Command port: drive mode/address/length/alignment/limit with start high while
// busy is low; the request is taken on that edge and busy rises next cycle.
// Exactly one result per request: granted and status are valid for a single
// cycle while done is high; the receiver cannot hold results off.
// The table memory is read one entry per cycle (registered read); a scan
// visits one extent at a time: it issues the read, waits for it, then tests
// it. An allocate with a nonzero alignment also waits on the serial
// remainder unit. Inserting or removing an entry shifts the entries above
// it, each one read and then written back one place over. One request at a
// time.
// Reset empties the table (the count goes to zero); table contents are left
// as they are and never read past the count.
module free_extent_allocator #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] address,
    input  logic [63:0] length,
    input  logic [63:0] alignment,
    input  logic [63:0] limit,
    output logic        done,
    output logic [63:0] granted,
    output logic [2:0]  status
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [63:0] PAGE   = 64'(fea_pkg::PAGE_BYTES);
    localparam logic [63:0] PMASK  = 64'(fea_pkg::PAGE_BYTES - 1);
    localparam logic [63:0] CLIPPED = fea_pkg::ALL_ONES - (fea_pkg::ALL_ONES % PAGE);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] ONE  = CW'(1);

    // table memories
    logic [63:0] mem_base [TABLE_ENTRIES];
    logic [63:0] mem_size [TABLE_ENTRIES];
    logic [63:0] rd_base_reg, rd_size_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [63:0]   wr_base, wr_size;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_base[wr_addr] <= wr_base;
            mem_size[wr_addr] <= wr_size;
        end
        rd_base_reg <= mem_base[rd_addr];
        rd_size_reg <= mem_size[rd_addr];
    end

    fea_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan / shift index
    logic [CW-1:0] pos_reg, pos_next;     // target position
    logic          mode_reg, mode_next;
    logic [63:0]   addr_reg, addr_next;
    logic [63:0]   size_reg, size_next;   // rounded length
    logic [63:0]   algn_reg, algn_next;
    logic [63:0]   lim_reg, lim_next;
    logic [63:0]   need_reg, need_next;
    logic [63:0]   eb_reg, eb_next;       // found extent base
    logic [63:0]   es_reg, es_next;       // found extent size
    logic [63:0]   lb_reg, lb_next;       // lower neighbor base
    logic [63:0]   ls_reg, ls_next;
    logic          haslo_reg, haslo_next;
    logic [63:0]   skip_reg, skip_next;
    logic [63:0]   gnt_reg, gnt_next;
    logic [2:0]    st_reg, st_next;
    // final write after shift: entry pos gets fb0/fs0, optional pos+1 gets fb1/fs1
    logic [63:0]   fb0_reg, fb0_next, fs0_reg, fs0_next;
    logic [63:0]   fb1_reg, fb1_next, fs1_reg, fs1_next;
    logic          fw1_reg, fw1_next;
    logic          fw0_reg, fw0_next;

    logic          div_go, div_done;
    logic [63:0]   div_rem;

    // remainder of the extent base just read, started in the same cycle as the hit
    fea_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (rd_base_reg),
        .divisor   (algn_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // input rounding
    logic [63:0] in_rem, in_add, in_round;
    logic        in_ovf;
    always_comb
    begin
        in_rem   = length & PMASK;
        in_add   = PAGE - in_rem;
        in_ovf   = (in_rem != 0) && (length > fea_pkg::ALL_ONES - in_add);
        in_round = (in_rem == 0) ? length : length + in_add;
    end

    logic [63:0] ent_end;
    logic        fit;
    logic [63:0] rest;
    always_comb
    begin
        ent_end = rd_base_reg + rd_size_reg;
        fit = (rd_size_reg >= need_reg) &&
              ((lim_reg == fea_pkg::ALL_ONES) ||
               (ent_end >= rd_base_reg && ent_end < lim_reg));
        rest = es_reg - skip_reg - size_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg; pos_next = pos_reg;
        mode_next = mode_reg; addr_next = addr_reg; size_next = size_reg;
        algn_next = algn_reg; lim_next = lim_reg; need_next = need_reg;
        eb_next = eb_reg; es_next = es_reg; lb_next = lb_reg; ls_next = ls_reg;
        haslo_next = haslo_reg; skip_next = skip_reg;
        gnt_next = gnt_reg; st_next = st_reg;
        fb0_next = fb0_reg; fs0_next = fs0_reg; fb1_next = fb1_reg;
        fs1_next = fs1_reg; fw1_next = fw1_reg; fw0_next = fw0_reg;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0; wr_addr = pos_reg[IW-1:0];
        wr_base = fb0_reg; wr_size = fs0_reg;
        div_go = 1'b0;
        unique case (state_reg)
            fea_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode; addr_next = address; algn_next = alignment;
                    lim_next = limit; gnt_next = '0; st_next = fea_pkg::ST_OK;
                    size_next = in_ovf ? CLIPPED : in_round;
                    need_next = in_round + alignment;
                    haslo_next = 1'b0;
                    state_next = fea_pkg::S_DONE;
                    if (length == 0)
                        st_next = fea_pkg::ST_ZERO_LEN;
                    else if (mode == fea_pkg::OP_FREE)
                    begin
                        idx_next = '0;
                        state_next = fea_pkg::S_PREP;
                    end
                    else if ((alignment & PMASK) != 0)
                        st_next = fea_pkg::ST_BAD_ALIGN;
                    else if (in_ovf || in_round > fea_pkg::ALL_ONES - alignment)
                        st_next = fea_pkg::ST_NO_FIT;
                    else
                    begin
                        idx_next = count_reg;
                        state_next = fea_pkg::S_PREP;
                    end
                end
            end
            fea_pkg::S_PREP:
            begin
                // alloc scans from the top down, free from the bottom up
                if (mode_reg == fea_pkg::OP_ALLOC)
                begin
                    if (idx_reg == 0)
                    begin
                        st_next = fea_pkg::ST_NO_FIT;
                        state_next = fea_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg - ONE;
                        state_next = fea_pkg::S_SCAN;
                    end
                end
                else if (idx_reg == count_reg)
                begin
                    pos_next = idx_reg;
                    state_next = fea_pkg::S_APPLY;
                end
                else
                    state_next = fea_pkg::S_SCAN;
            end
            fea_pkg::S_SCAN:
            begin
                // memory read issued at idx
                state_next = fea_pkg::S_SCAN_WAIT;
            end
            fea_pkg::S_SCAN_WAIT:
            begin
                if (mode_reg == fea_pkg::OP_ALLOC)
                begin
                    if (fit)
                    begin
                        pos_next = idx_reg; eb_next = rd_base_reg; es_next = rd_size_reg;
                        skip_next = '0;
                        if (algn_reg != 0)
                        begin
                            div_go = 1'b1;
                            state_next = fea_pkg::S_REM;
                        end
                        else
                            state_next = fea_pkg::S_APPLY;
                        eb_next = rd_base_reg;
                    end
                    else
                        state_next = fea_pkg::S_PREP;
                end
                else if (rd_base_reg < addr_reg)
                begin
                    lb_next = rd_base_reg; ls_next = rd_size_reg; haslo_next = 1'b1;
                    idx_next = idx_reg + ONE;
                    state_next = fea_pkg::S_PREP;
                end
                else
                begin
                    pos_next = idx_reg; eb_next = rd_base_reg; es_next = rd_size_reg;
                    state_next = fea_pkg::S_APPLY;
                end
            end
            fea_pkg::S_REM:
            begin
                if (div_done)
                begin
                    skip_next = (div_rem != 0) ? algn_reg - div_rem : '0;
                    state_next = fea_pkg::S_APPLY;
                end
            end
            fea_pkg::S_APPLY:
            begin
                fw1_next = 1'b0; fw0_next = 1'b1;
                state_next = fea_pkg::S_DONE;
                if (mode_reg == fea_pkg::OP_ALLOC)
                begin
                    gnt_next = eb_reg + skip_reg;
                    if (skip_reg != 0 && rest != 0)
                    begin
                        if (count_reg >= FULL)
                        begin
                            gnt_next = '0; st_next = fea_pkg::ST_FULL;
                        end
                        else
                        begin
                            fb0_next = eb_reg; fs0_next = skip_reg;
                            fb1_next = eb_reg + skip_reg + size_reg; fs1_next = rest;
                            fw1_next = 1'b1;
                            count_next = count_reg + ONE;
                            idx_next = count_reg;
                            state_next = fea_pkg::S_SHIFT_UP;
                        end
                    end
                    else if (skip_reg != 0 || rest != 0)
                    begin
                        fb0_next = (skip_reg != 0) ? eb_reg : eb_reg + size_reg;
                        fs0_next = (skip_reg != 0) ? skip_reg : rest;
                        state_next = fea_pkg::S_FINAL;
                    end
                    else
                    begin
                        fw0_next = 1'b0;
                        idx_next = pos_reg;
                        count_next = count_reg - ONE;
                        state_next = fea_pkg::S_SHIFT_DN;
                    end
                end
                else
                begin
                    // free: merge with neighbors
                    if (haslo_reg && (lb_reg + ls_reg == addr_reg))
                    begin
                        if (pos_reg < count_reg && addr_reg + size_reg == eb_reg)
                        begin
                            fb0_next = lb_reg; fs0_next = ls_reg + size_reg + es_reg;
                            // remove pos, then write lower at pos-1
                            count_next = count_reg - ONE;
                            idx_next = pos_reg;
                            state_next = fea_pkg::S_SHIFT_DN;
                        end
                        else
                        begin
                            fb0_next = lb_reg; fs0_next = ls_reg + size_reg;
                            state_next = fea_pkg::S_FINAL;
                        end
                        pos_next = pos_reg - ONE;
                    end
                    else if (pos_reg < count_reg && addr_reg + size_reg == eb_reg)
                    begin
                        fb0_next = addr_reg; fs0_next = size_reg + es_reg;
                        state_next = fea_pkg::S_FINAL;
                    end
                    else if (count_reg >= FULL)
                        st_next = fea_pkg::ST_FULL;
                    else
                    begin
                        fb0_next = addr_reg; fs0_next = size_reg;
                        count_next = count_reg + ONE;
                        idx_next = count_reg;
                        state_next = fea_pkg::S_SHIFT_UP;
                    end
                end
            end
            fea_pkg::S_SHIFT_UP:
            begin
                // move entry idx-1 to idx, down to pos (+1 when two entries go in)
                if (idx_reg == pos_reg + CW'(fw1_reg))
                    state_next = fea_pkg::S_FINAL;
                else
                begin
                    rd_addr = IW'(idx_reg - ONE);
                    state_next = fea_pkg::S_SHIFT_UP_WR;
                end
            end
            fea_pkg::S_SHIFT_UP_WR:
            begin
                wr_en = 1'b1; wr_addr = idx_reg[IW-1:0];
                wr_base = rd_base_reg; wr_size = rd_size_reg;
                idx_next = idx_reg - ONE;
                state_next = fea_pkg::S_SHIFT_UP;
            end
            fea_pkg::S_SHIFT_DN:
            begin
                // move entry idx+1 to idx until the new count
                if (idx_reg >= count_reg)
                    state_next = fea_pkg::S_FINAL;
                else
                begin
                    rd_addr = IW'(idx_reg + ONE);
                    state_next = fea_pkg::S_SHIFT_DN_WR;
                end
            end
            fea_pkg::S_SHIFT_DN_WR:
            begin
                wr_en = 1'b1; wr_addr = idx_reg[IW-1:0];
                wr_base = rd_base_reg; wr_size = rd_size_reg;
                idx_next = idx_reg + ONE;
                state_next = fea_pkg::S_SHIFT_DN;
            end
            fea_pkg::S_FINAL:
            begin
                if (fw1_reg)
                begin
                    wr_en = 1'b1; wr_addr = IW'(pos_reg + ONE);
                    wr_base = fb1_reg; wr_size = fs1_reg;
                    fw1_next = 1'b0;
                end
                else
                begin
                    wr_en = fw0_reg;
                    state_next = fea_pkg::S_DONE;
                end
            end
            fea_pkg::S_DONE:
            begin
                state_next = fea_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fea_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fea_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; pos_reg <= pos_next; mode_reg <= mode_next;
        addr_reg <= addr_next; size_reg <= size_next; algn_reg <= algn_next;
        lim_reg <= lim_next; need_reg <= need_next; eb_reg <= eb_next;
        es_reg <= es_next; lb_reg <= lb_next; ls_reg <= ls_next;
        haslo_reg <= haslo_next; skip_reg <= skip_next; gnt_reg <= gnt_next;
        st_reg <= st_next; fb0_reg <= fb0_next; fs0_reg <= fs0_next;
        fb1_reg <= fb1_next; fs1_reg <= fs1_next; fw1_reg <= fw1_next;
        fw0_reg <= fw0_next;
    end

    assign busy    = (state_reg != fea_pkg::S_IDLE);
    assign done    = (state_reg == fea_pkg::S_DONE);
    assign granted = gnt_reg;
    assign status  = st_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL) else $error("extent count beyond table");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && st_reg != fea_pkg::ST_OK |-> gnt_reg == 0)
        else $error("nonzero grant on failure");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request not taken");

endmodule

// ===== tb/free_extent_allocator_tb.sv =====
// free_extent_allocator_tb: self-checking testbench for the free extent allocator
// depends on fea_pkg and the free_extent_allocator rtl
// a directed table of requests, a table fill and drain, then random alloc/free traffic against a local table model
module free_extent_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ENTRIES  = 64;
    localparam int          PAGE     = fea_pkg::PAGE_BYTES;
    localparam logic [63:0] PAGE_W   = 64'(PAGE);
    localparam logic [63:0] MAX_PAGE = fea_pkg::ALL_ONES - (fea_pkg::ALL_ONES % PAGE_W);
    localparam int          N_RANDOM = 950;

    typedef struct packed {
        logic        mode;
        logic [63:0] address;
        logic [63:0] length;
        logic [63:0] alignment;
        logic [63:0] limit;
    } request_t;

    typedef struct packed {
        logic [63:0]      granted;
        fea_pkg::status_t status;
    } answer_t;

    // directed row: request plus optional typed-in answer
    typedef struct packed {
        request_t req;
        logic     known;
        answer_t  ans;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [63:0] address;
    logic [63:0] length;
    logic [63:0] alignment;
    logic [63:0] limit;
    logic        done;
    logic [63:0] granted;
    logic [2:0]  status;

    // local copy of the free extent table
    logic [63:0] free_base [ENTRIES];
    logic [63:0] free_size [ENTRIES];
    int          free_count;

    answer_t     pending_answers [$];
    int          n_errors;
    int          n_answers;
    int          n_alloc_ok;
    int          n_free_ok;
    int          n_full;
    int          n_nofit;

    free_extent_allocator #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .address  (address),
        .length   (length),
        .alignment(alignment),
        .limit    (limit),
        .done     (done),
        .granted  (granted),
        .status   (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("free_extent_allocator_tb failed");
        $finish;
    end

    // table shifting helpers
    function automatic void drop_entry(input int i);
        for (int k = i; k + 1 < free_count; k++)
        begin
            free_base[k] = free_base[k + 1];
            free_size[k] = free_size[k + 1];
        end
        free_count--;
    endfunction

    function automatic void add_entry(input int i, input logic [63:0] b,
                                      input logic [63:0] s);
        for (int k = free_count; k > i; k--)
        begin
            free_base[k] = free_base[k - 1];
            free_size[k] = free_size[k - 1];
        end
        free_base[i] = b;
        free_size[i] = s;
        free_count++;
    endfunction

    // page rounding, ok low on overflow
    function automatic logic [63:0] page_round(input logic [63:0] x, output logic ok);
        logic [63:0] rem;
        logic [63:0] pad;
        rem = x % PAGE_W;
        ok  = 1'b1;
        if (rem == 0)
            return x;
        pad = PAGE_W - rem;
        if (x > fea_pkg::ALL_ONES - pad)
        begin
            ok = 1'b0;
            return 64'd0;
        end
        return x + pad;
    endfunction

    function automatic answer_t carve_extent(input request_t r);
        answer_t     a;
        logic        ok;
        logic        hit;
        logic [63:0] asize;
        logic [63:0] need;
        logic [63:0] b;
        logic [63:0] skip;
        logic [63:0] rest;
        logic [63:0] fin;
        int          j;
        a.granted = '0;
        hit = 1'b0;
        j = 0;
        if (r.length == 0)
        begin
            a.status = fea_pkg::ST_ZERO_LEN;
            return a;
        end
        if (r.alignment % PAGE_W != 0)
        begin
            a.status = fea_pkg::ST_BAD_ALIGN;
            return a;
        end
        asize = page_round(r.length, ok);
        if (!ok || asize > fea_pkg::ALL_ONES - r.alignment)
        begin
            a.status = fea_pkg::ST_NO_FIT;
            return a;
        end
        need = asize + r.alignment;
        // highest extent first
        for (int i = free_count - 1; i >= 0 && !hit; i--)
        begin
            fin = free_base[i] + free_size[i];
            if (free_size[i] >= need &&
                (r.limit == fea_pkg::ALL_ONES || (fin >= free_base[i] && fin < r.limit)))
            begin
                hit = 1'b1;
                j = i;
            end
        end
        if (!hit)
        begin
            a.status = fea_pkg::ST_NO_FIT;
            return a;
        end
        b = free_base[j];
        skip = 0;
        if (r.alignment != 0 && b % r.alignment != 0)
            skip = r.alignment - b % r.alignment;
        rest = free_size[j] - skip - asize;
        if (skip != 0)
        begin
            if (rest != 0)
            begin
                if (free_count >= ENTRIES)
                begin
                    a.status = fea_pkg::ST_FULL;
                    return a;
                end
                add_entry(j, b, skip);
                free_base[j + 1] = b + skip + asize;
                free_size[j + 1] = rest;
            end
            else
                free_size[j] = skip;
        end
        else if (rest != 0)
        begin
            free_base[j] = b + asize;
            free_size[j] = rest;
        end
        else
            drop_entry(j);
        a.granted = b + skip;
        a.status = fea_pkg::ST_OK;
        return a;
    endfunction

    function automatic answer_t return_extent(input request_t r);
        answer_t     a;
        logic        ok;
        logic        lo;
        logic        hi;
        logic [63:0] sz;
        int          p;
        a.granted = '0;
        a.status  = fea_pkg::ST_OK;
        if (r.length == 0)
        begin
            a.status = fea_pkg::ST_ZERO_LEN;
            return a;
        end
        sz = page_round(r.length, ok);
        if (!ok)
            sz = MAX_PAGE;
        p = 0;
        while (p < free_count && free_base[p] < r.address)
            p++;
        lo = (p > 0) && (free_base[p - 1] + free_size[p - 1] == r.address);
        hi = (p < free_count) && (r.address + sz == free_base[p]);
        if (lo)
        begin
            free_size[p - 1] += sz;
            if (hi)
            begin
                free_size[p - 1] += free_size[p];
                drop_entry(p);
            end
        end
        else if (hi)
        begin
            free_base[p] = r.address;
            free_size[p] += sz;
        end
        else if (free_count >= ENTRIES)
            a.status = fea_pkg::ST_FULL;
        else
            add_entry(p, r.address, sz);
        return a;
    endfunction

    function automatic answer_t predict_answer(input request_t r);
        if (r.mode == fea_pkg::OP_FREE)
            return return_extent(r);
        return carve_extent(r);
    endfunction

    // result checker, sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done)
        begin
            n_answers++;
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result granted=%h status=%0d", granted, status);
                n_errors++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (granted !== e.granted)
                begin
                    $error("granted: expected %h, actual %h", e.granted, granted);
                    n_errors++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    n_errors++;
                end
                if (e.status == fea_pkg::ST_FULL)
                    n_full++;
                if (e.status == fea_pkg::ST_NO_FIT)
                    n_nofit++;
            end
        end
    end

    // send one request, then release start after acceptance
    task automatic send_request(input request_t r, input logic known, input answer_t typed);
        answer_t a;
        start     <= 1'b1;
        mode      <= r.mode;
        address   <= r.address;
        length    <= r.length;
        alignment <= r.alignment;
        limit     <= r.limit;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        a = predict_answer(r);
        if (known && a != typed)
        begin
            $error("table row: expected %h/%0d, model %h/%0d",
                   typed.granted, typed.status, a.granted, a.status);
            n_errors++;
        end
        if (a.status == fea_pkg::ST_OK)
        begin
            if (r.mode == fea_pkg::OP_FREE) n_free_ok++;
            else n_alloc_ok++;
        end
        pending_answers.push_back(a);
        start <= 1'b0;
        // the block is busy for at least this cycle anyway
        @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random request, mostly well formed page-sized traffic in a small window
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        r.mode      = 1'($urandom_range(0, 1));
        r.address   = 64'h10_0000 + 64'($urandom_range(0, 1023)) * PAGE_W;
        r.length    = 64'($urandom_range(1, 24)) * PAGE_W - 64'($urandom_range(0, 1)
                      ? $urandom_range(0, PAGE - 1) : 0);
        r.alignment = 64'($urandom_range(0, 1) ? 0 : (1 << $urandom_range(12, 18)));
        r.limit     = $urandom_range(0, 2) ? fea_pkg::ALL_ONES
                      : 64'h10_0000 + 64'($urandom_range(0, 1100)) * PAGE_W;
        if (pick < 5)
        begin
            // noise: full-range fields
            r.address   = rand64();
            r.length    = rand64();
            r.alignment = $urandom_range(0, 1) ? rand64() : rand64() & ~(PAGE_W - 1);
            r.limit     = rand64();
        end
        else if (pick < 8)
            r.length = 0;
        else if (pick < 10)
            r.alignment = r.alignment | 64'($urandom_range(1, PAGE - 1));
        return r;
    endfunction

    // stimulus
    initial
    begin
        row_t     rows [$];
        request_t r;
        answer_t  none;
        n_errors   = 0;
        n_answers  = 0;
        n_alloc_ok = 0;
        n_free_ok  = 0;
        n_full     = 0;
        n_nofit    = 0;
        free_count = 0;
        none       = '0;
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = 1'b0;
        address    = '0;
        length     = '0;
        alignment  = '0;
        limit      = fea_pkg::ALL_ONES;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'd0, fea_pkg::ALL_ONES},
                         1'b1, '{64'd0, fea_pkg::ST_NO_FIT}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'd0, 64'd0, fea_pkg::ALL_ONES},
                         1'b1, '{64'd0, fea_pkg::ST_ZERO_LEN}});
        rows.push_back('{'{fea_pkg::OP_FREE, 64'h5000, 64'd0, 64'd0, 64'd0}, 1'b1,
                         '{64'd0, fea_pkg::ST_ZERO_LEN}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'h800, fea_pkg::ALL_ONES},
                         1'b1, '{64'd0, fea_pkg::ST_BAD_ALIGN}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, fea_pkg::ALL_ONES, 64'd0,
                           fea_pkg::ALL_ONES}, 1'b1, '{64'd0, fea_pkg::ST_NO_FIT}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, fea_pkg::ALL_ONES & ~64'hFFF,
                           fea_pkg::ALL_ONES}, 1'b1, '{64'd0, fea_pkg::ST_NO_FIT}});
        // extent at zero and one at the very top with clipped length
        rows.push_back('{'{fea_pkg::OP_FREE, 64'd0, 64'h4000, fea_pkg::ALL_ONES, 64'd0},
                         1'b1, '{64'd0, fea_pkg::ST_OK}});
        rows.push_back('{'{fea_pkg::OP_FREE, 64'hFFFF_FFFF_FFFF_0000, fea_pkg::ALL_ONES,
                           64'd0, 64'd0}, 1'b1, '{64'd0, fea_pkg::ST_OK}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'd0, 64'h8000}, 1'b1,
                         '{64'd0, fea_pkg::ST_OK}});
        // merge both sides
        rows.push_back('{'{fea_pkg::OP_FREE, 64'h20000, 64'h1000, 64'd0, 64'd0}, 1'b0, none});
        rows.push_back('{'{fea_pkg::OP_FREE, 64'h22000, 64'h1000, 64'd0, 64'd0}, 1'b0, none});
        rows.push_back('{'{fea_pkg::OP_FREE, 64'h21000, 64'h1, 64'd0, 64'd0}, 1'b0, none});
        // aligned split with leading remainder, limits
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'h2000, 64'h30000},
                         1'b0, none});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h800, 64'h10000, fea_pkg::ALL_ONES},
                         1'b0, none});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'd0, 64'd0}, 1'b1,
                         '{64'd0, fea_pkg::ST_NO_FIT}});
        rows.push_back('{'{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'd0, fea_pkg::ALL_ONES - 1},
                         1'b0, none});
        rows.push_back('{'{fea_pkg::OP_FREE, fea_pkg::ALL_ONES, fea_pkg::ALL_ONES, 64'd0,
                           64'd0}, 1'b0, none});
        foreach (rows[i])
        begin
            send_request(rows[i].req, rows[i].known, rows[i].ans);
            idle_gap();
        end
        // fill the table with isolated pages to reach the full cases
        for (int i = 0; i < ENTRIES + 2; i++)
        begin
            r = '{fea_pkg::OP_FREE, 64'h100_0000 + 64'(i) * 64'h2000, 64'h1000, 64'd0, 64'd0};
            send_request(r, 1'b0, none);
        end
        r = '{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'h2000, fea_pkg::ALL_ONES};
        send_request(r, 1'b0, none);

        // hold off until every answer is back
        while (pending_answers.size() != 0)
            @(posedge clk);
        // drain the table back down with allocations
        for (int i = 0; i < ENTRIES + 4; i++)
        begin
            r = '{fea_pkg::OP_ALLOC, 64'd0, 64'h1000, 64'd0, fea_pkg::ALL_ONES};
            send_request(r, 1'b0, none);
            idle_gap();
        end

        // random traffic
        for (int i = 0; i < N_RANDOM; i++)
        begin
            send_request(random_request(), 1'b0, none);
            idle_gap();
        end

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d results: %0d allocs ok, %0d frees ok,", n_answers,
                 n_alloc_ok, n_free_ok);
        $display("%0d no fit, %0d table full, over a full table and random traffic",
                 n_nofit, n_full);
        if (n_errors == 0 && pending_answers.size() == 0)
            $display("free_extent_allocator_tb passed");
        else
            $display("free_extent_allocator_tb failed");
        $finish;
    end

endmodule
